@@ hw/rtl/vole_pkg.sv @@
// Shared types, opcodes and sizes for the instruction execute block.
`default_nettype none
package vole_pkg;

   localparam int MEM_DEPTH_DEF = 256;
   localparam int REG_COUNT_DEF = 16;

   typedef enum logic [3:0] {
      OP_LOAD_MEM = 4'h1,
      OP_LOAD_IMM = 4'h2,
      OP_STORE    = 4'h3,
      OP_MOVE     = 4'h4,
      OP_ADD_INT  = 4'h5,
      OP_ADD_FLT  = 4'h6,
      OP_OR       = 4'h7,
      OP_AND      = 4'h8,
      OP_XOR      = 4'h9,
      OP_ROTATE   = 4'hA,
      OP_JUMP_EQ  = 4'hB,
      OP_HALT     = 4'hC
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic       reg_we;
      logic [7:0] reg_wdata;
      logic       mem_we;
      logic       jump_taken;
      logic [7:0] jump_target;
      logic       halted;
      logic       screen_valid;
      logic [7:0] screen_byte;
      logic       bad_opcode;
   } alu_out_type;

endpackage
`default_nettype wire

@@ hw/rtl/vole_instruction_execute.sv @@
// Top level: request capture, register file and data memory, execute and response register.
// Operands are read into registers when a request is accepted (operand read), then it executes,
// writes back and loads the response register. No new request is taken while one executes.
// A new request waits until the output register is empty or drains in the same cycle.
// Reset clears the control state and the valid bits of both memories, so every
// register and memory byte reads as zero until written; no clearing pass is needed.
`default_nettype none
module vole_instruction_execute
   import vole_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int REG_COUNT = REG_COUNT_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_instruction_word,
   input  wire logic [7:0]  req_load_address,
   input  wire logic [7:0]  req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_jump_taken,
   output logic [7:0]       rsp_jump_target,
   output logic             rsp_halted,
   output logic             rsp_screen_valid,
   output logic [7:0]       rsp_screen_byte,
   output logic             rsp_bad_opcode
);

   localparam int MA_W = $clog2(MEM_DEPTH);
   localparam int RA_W = $clog2(REG_COUNT);

   logic [7:0]  reg_mem [REG_COUNT];
   logic [7:0]  data_mem [MEM_DEPTH];
   logic [REG_COUNT-1:0] reg_vld_ff;
   logic [MEM_DEPTH-1:0] mem_vld_ff;

   state_type   state_ff, state_in;
   logic        accept;
   logic [3:0]  req_op;
   logic [RA_W-1:0] rd_a_addr, rd_b_addr;
   logic [MA_W-1:0] rd_m_addr;

   logic        mode_ff;
   logic [15:0] instr_ff;
   logic [7:0]  laddr_ff;
   logic [7:0]  ldata_ff;
   logic [7:0]  rd_a_ff, rd_b_ff, rd_m_ff;
   logic        rd_a_vld_ff, rd_b_vld_ff, rd_m_vld_ff;
   logic [7:0]  val_a, val_b, mem_val;
   logic [RA_W-1:0] wr_addr;
   logic [MA_W-1:0] mem_waddr;
   logic [7:0]  mem_wdata;
   logic        mem_we;
   logic        exec;
   alu_out_type alu_out;

   logic        rsp_valid_ff;
   alu_out_type rsp_ff;

   assign accept = req_valid && req_ready;
   assign exec   = (state_ff == ST_EXEC);
   assign req_op = req_instruction_word[15:12];

   always_comb begin
      if (req_op == OP_MOVE || req_op == OP_ADD_INT || req_op == OP_ADD_FLT ||
          req_op == OP_OR || req_op == OP_AND || req_op == OP_XOR) begin
         rd_a_addr = RA_W'(req_instruction_word[7:4]);
      end else begin
         rd_a_addr = RA_W'(req_instruction_word[11:8]);
      end
      if (req_op == OP_JUMP_EQ) begin
         rd_b_addr = '0;
      end else begin
         rd_b_addr = RA_W'(req_instruction_word[3:0]);
      end
      rd_m_addr = MA_W'(req_instruction_word[7:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // capture request and read operands
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         instr_ff <= req_instruction_word;
         laddr_ff <= req_load_address;
         ldata_ff <= req_load_data;
         rd_a_ff  <= reg_mem[rd_a_addr];
         rd_b_ff  <= reg_mem[rd_b_addr];
         rd_m_ff  <= data_mem[rd_m_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_a_vld_ff <= 1'b0;
         rd_b_vld_ff <= 1'b0;
         rd_m_vld_ff <= 1'b0;
      end else if (accept) begin
         rd_a_vld_ff <= reg_vld_ff[rd_a_addr];
         rd_b_vld_ff <= reg_vld_ff[rd_b_addr];
         rd_m_vld_ff <= mem_vld_ff[rd_m_addr];
      end
   end

   assign val_a   = rd_a_vld_ff ? rd_a_ff : 8'h00;
   assign val_b   = rd_b_vld_ff ? rd_b_ff : 8'h00;
   assign mem_val = rd_m_vld_ff ? rd_m_ff : 8'h00;

   vole_alu u_alu (
      .load_mode (mode_ff),
      .instr     (instr_ff),
      .val_a     (val_a),
      .val_b     (val_b),
      .mem_val   (mem_val),
      .alu_out   (alu_out)
   );

   always_comb begin
      if (instr_ff[15:12] == OP_MOVE) begin
         wr_addr = RA_W'(instr_ff[3:0]);
      end else begin
         wr_addr = RA_W'(instr_ff[11:8]);
      end
      if (mode_ff) begin
         mem_waddr = MA_W'(laddr_ff);
         mem_wdata = ldata_ff;
      end else begin
         mem_waddr = MA_W'(instr_ff[7:0]);
         mem_wdata = val_a;
      end
      mem_we = exec && (mode_ff || alu_out.mem_we);
   end

   // write back
   always_ff @(posedge clock) begin
      if (exec && alu_out.reg_we) begin
         reg_mem[wr_addr] <= alu_out.reg_wdata;
      end
      if (mem_we) begin
         data_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
         mem_vld_ff <= '0;
      end else begin
         if (exec && alu_out.reg_we) begin
            reg_vld_ff[wr_addr] <= 1'b1;
         end
         if (mem_we) begin
            mem_vld_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= alu_out;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_jump_taken   = rsp_ff.jump_taken;
   assign rsp_jump_target  = rsp_ff.jump_target;
   assign rsp_halted       = rsp_ff.halted;
   assign rsp_screen_valid = rsp_ff.screen_valid;
   assign rsp_screen_byte  = rsp_ff.screen_byte;
   assign rsp_bad_opcode   = rsp_ff.bad_opcode;

endmodule
`default_nettype wire

@@ hw/rtl/vole_alu.sv @@
// Operation decode and datapath: load, integer, float, logic, rotate, jump, store, halt and bad-opcode results.
`default_nettype none
module vole_alu
   import vole_pkg::*;
(
   input  wire logic        load_mode,
   input  wire logic [15:0] instr,
   input  wire logic [7:0]  val_a,
   input  wire logic [7:0]  val_b,
   input  wire logic [7:0]  mem_val,
   output alu_out_type      alu_out
);

   logic [3:0]         op;
   logic [7:0]         xy;
   logic [2:0]         rot;
   logic [15:0]        rot_wide;
   logic [10:0]        fa_mag;
   logic [10:0]        fb_mag;
   logic signed [12:0] fa_s;
   logic signed [12:0] fb_s;
   logic signed [12:0] fsum;
   logic [11:0]        fmag;
   logic [3:0]         fexp;
   logic [11:0]        fshift;
   logic [7:0]         fres;

   assign op       = instr[15:12];
   assign xy       = instr[7:0];
   assign rot      = instr[2:0];
   assign rot_wide = {val_a, val_a} >> rot;

   always_comb begin
      fa_mag = 11'({7'b0, val_a[3:0]} << val_a[6:4]);
      fb_mag = 11'({7'b0, val_b[3:0]} << val_b[6:4]);
      fa_s   = val_a[7] ? -$signed({2'b0, fa_mag}) : $signed({2'b0, fa_mag});
      fb_s   = val_b[7] ? -$signed({2'b0, fb_mag}) : $signed({2'b0, fb_mag});
      fsum   = fa_s + fb_s;
      fmag   = fsum[12] ? 12'(-fsum) : fsum[11:0];
      fexp   = 4'd0;
      for (int i = 1; i <= 8; i++) begin
         if (fmag[i + 3]) begin
            fexp = 4'(i);
         end
      end
      fshift = fmag >> fexp;
      if (fsum == 13'sd0) begin
         fres = 8'h00;
      end else if (fexp[3]) begin
         fres = {fsum[12], 7'h7F};
      end else begin
         fres = {fsum[12], fexp[2:0], fshift[3:0]};
      end
   end

   always_comb begin
      alu_out = '0;
      if (!load_mode) begin
         case (op)
            OP_LOAD_MEM: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = mem_val;
            end
            OP_LOAD_IMM: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = xy;
            end
            OP_STORE: begin
               alu_out.mem_we = 1'b1;
               if (xy == 8'h00) begin
                  alu_out.screen_valid = 1'b1;
                  alu_out.screen_byte  = val_a;
               end
            end
            OP_MOVE: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = val_a;
            end
            OP_ADD_INT: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = val_a + val_b;
            end
            OP_ADD_FLT: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = fres;
            end
            OP_OR: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = val_a | val_b;
            end
            OP_AND: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = val_a & val_b;
            end
            OP_XOR: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = val_a ^ val_b;
            end
            OP_ROTATE: begin
               alu_out.reg_we    = 1'b1;
               alu_out.reg_wdata = rot_wide[7:0];
            end
            OP_JUMP_EQ: begin
               if (val_a == val_b) begin
                  alu_out.jump_taken  = 1'b1;
                  alu_out.jump_target = xy;
               end
            end
            OP_HALT: begin
               alu_out.halted = 1'b1;
            end
            default: begin
               alu_out.bad_opcode = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ test/vole_checker.sv @@
// Request/response monitor with an instruction-level predictor for the execute block.
module vole_checker
   import vole_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_instruction_word,
   input  wire logic [7:0]  req_load_address,
   input  wire logic [7:0]  req_load_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_jump_taken,
   input  wire logic [7:0]  rsp_jump_target,
   input  wire logic        rsp_halted,
   input  wire logic        rsp_screen_valid,
   input  wire logic [7:0]  rsp_screen_byte,
   input  wire logic        rsp_bad_opcode,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       jump_taken;
      logic [7:0] jump_target;
      logic       halted;
      logic       screen_valid;
      logic [7:0] screen_byte;
      logic       bad_opcode;
   } exec_result_t;

   logic [7:0]   shadow_regs [REG_COUNT_DEF];
   logic [7:0]   shadow_mem  [MEM_DEPTH_DEF];
   exec_result_t awaited_results [$];

   function automatic logic [7:0] float8_add(logic [7:0] a, logic [7:0] b);
      int         va;
      int         vb;
      int         sum;
      int         mag;
      int         e;
      logic [7:0] sign;
      va = int'(a[3:0]) << a[6:4];
      vb = int'(b[3:0]) << b[6:4];
      if (a[7]) va = -va;
      if (b[7]) vb = -vb;
      sum = va + vb;
      if (sum == 0) return 8'h00;
      sign = (sum < 0) ? 8'h80 : 8'h00;
      mag = (sum < 0) ? -sum : sum;
      e = 8;
      while (e > 0 && ((mag >> e) & 8) == 0) e--;
      if (e > 7) return sign | 8'h7F;
      return sign | 8'(e << 4) | 8'((mag >> e) & 15);
   endfunction

   function automatic exec_result_t execute_request(logic mode, logic [15:0] word,
                                                    logic [7:0] addr, logic [7:0] data);
      exec_result_t res;
      logic [3:0]   r;
      logic [3:0]   s;
      logic [3:0]   t;
      logic [7:0]   xy;
      logic [15:0]  spun;
      res = '0;
      r = word[11:8];
      s = word[7:4];
      t = word[3:0];
      xy = word[7:0];
      if (mode) begin
         shadow_mem[addr] = data;
         return res;
      end
      case (word[15:12])
         OP_LOAD_MEM: shadow_regs[r] = shadow_mem[xy];
         OP_LOAD_IMM: shadow_regs[r] = xy;
         OP_STORE: begin
            shadow_mem[xy] = shadow_regs[r];
            if (xy == 8'h00) begin
               res.screen_valid = 1'b1;
               res.screen_byte = shadow_regs[r];
            end
         end
         OP_MOVE:    shadow_regs[t] = shadow_regs[s];
         OP_ADD_INT: shadow_regs[r] = shadow_regs[s] + shadow_regs[t];
         OP_ADD_FLT: shadow_regs[r] = float8_add(shadow_regs[s], shadow_regs[t]);
         OP_OR:      shadow_regs[r] = shadow_regs[s] | shadow_regs[t];
         OP_AND:     shadow_regs[r] = shadow_regs[s] & shadow_regs[t];
         OP_XOR:     shadow_regs[r] = shadow_regs[s] ^ shadow_regs[t];
         OP_ROTATE: begin
            spun = {shadow_regs[r], shadow_regs[r]} >> t[2:0];
            shadow_regs[r] = spun[7:0];
         end
         OP_JUMP_EQ: begin
            if (shadow_regs[r] == shadow_regs[0]) begin
               res.jump_taken = 1'b1;
               res.jump_target = xy;
            end
         end
         OP_HALT: res.halted = 1'b1;
         default: res.bad_opcode = 1'b1;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      exec_result_t want;
      exec_result_t got;
      if (reset) begin
         for (int i = 0; i < REG_COUNT_DEF; i++) shadow_regs[i] = 8'h00;
         for (int i = 0; i < MEM_DEPTH_DEF; i++) shadow_mem[i] = 8'h00;
         awaited_results.delete();
         fail_count = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_jump_taken, rsp_jump_target, rsp_halted,
                   rsp_screen_valid, rsp_screen_byte, rsp_bad_opcode};
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t unexpected response: jt=%0b tgt=%02h halt=%0b scr=%0b byte=%02h bad=%0b",
                        $time, got.jump_taken, got.jump_target, got.halted,
                        got.screen_valid, got.screen_byte, got.bad_opcode);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t mismatch: expected jt=%0b tgt=%02h halt=%0b scr=%0b byte=%02h bad=%0b",
                           $time, want.jump_taken, want.jump_target, want.halted,
                           want.screen_valid, want.screen_byte, want.bad_opcode);
                  $display("%0t            actual jt=%0b tgt=%02h halt=%0b scr=%0b byte=%02h bad=%0b",
                           $time, got.jump_taken, got.jump_target, got.halted,
                           got.screen_valid, got.screen_byte, got.bad_opcode);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(execute_request(req_mode, req_instruction_word,
                                                      req_load_address, req_load_data));
         outstanding <= awaited_results.size();
      end
   end

endmodule

@@ test/testbench.sv @@
// Stimulus, response backpressure and verdict for the instruction execute block.
module testbench
   import vole_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       MODE_EXEC   = 1'b0;
   localparam logic       MODE_LOAD   = 1'b1;
   localparam logic [3:0] OP_BAD_ZERO = 4'h0;
   localparam logic [3:0] OP_BAD_D    = 4'hD;
   localparam logic [3:0] OP_BAD_E    = 4'hE;
   localparam logic [3:0] OP_BAD_F    = 4'hF;
   localparam int         RANDOM_REQUESTS = 1600;
   localparam int         CYCLE_LIMIT     = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [15:0] req_instruction_word = 16'h0000;
   logic [7:0]  req_load_address = 8'h00;
   logic [7:0]  req_load_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_jump_taken;
   logic [7:0]  rsp_jump_target;
   logic        rsp_halted;
   logic        rsp_screen_valid;
   logic [7:0]  rsp_screen_byte;
   logic        rsp_bad_opcode;
   int          fail_count;
   int          outstanding;
   int          cycle_count;
   logic        sender_steady = 1'b0;

   vole_instruction_execute dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_instruction_word (req_instruction_word),
      .req_load_address     (req_load_address),
      .req_load_data        (req_load_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_jump_taken       (rsp_jump_taken),
      .rsp_jump_target      (rsp_jump_target),
      .rsp_halted           (rsp_halted),
      .rsp_screen_valid     (rsp_screen_valid),
      .rsp_screen_byte      (rsp_screen_byte),
      .rsp_bad_opcode       (rsp_bad_opcode)
   );

   vole_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_instruction_word (req_instruction_word),
      .req_load_address     (req_load_address),
      .req_load_data        (req_load_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_jump_taken       (rsp_jump_taken),
      .rsp_jump_target      (rsp_jump_target),
      .rsp_halted           (rsp_halted),
      .rsp_screen_valid     (rsp_screen_valid),
      .rsp_screen_byte      (rsp_screen_byte),
      .rsp_bad_opcode       (rsp_bad_opcode),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_request(logic mode, logic [15:0] word, logic [7:0] addr,
                               logic [7:0] data);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_instruction_word <= word;
      req_load_address <= addr;
      req_load_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic exec(logic [15:0] word);
      send_request(MODE_EXEC, word, 8'($urandom), 8'($urandom));
   endtask

   // receiver: random stall before each response, with steady stretches
   initial begin
      int   stall;
      int   served;
      logic steady;
      served = 0;
      steady = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (served % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         served++;
      end
   end

   initial begin
      logic [15:0] word;
      logic [7:0]  addr;
      int          pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_LOAD, 16'hFFFF, 8'hFF, 8'hFF);
      send_request(MODE_LOAD, 16'h0000, 8'h00, 8'hA5);
      exec({OP_LOAD_MEM, 12'h1FF});
      exec({OP_LOAD_IMM, 12'h27F});
      exec({OP_LOAD_IMM, 12'h37F});
      // float overflow, both signs, and a zero sum
      exec({OP_ADD_FLT, 12'h423});
      exec({OP_LOAD_IMM, 12'h5FF});
      exec({OP_ADD_FLT, 12'h655});
      exec({OP_ADD_FLT, 12'h725});
      exec({OP_ADD_INT, 12'h815});
      exec({OP_OR, 12'h928});
      exec({OP_AND, 12'hA28});
      exec({OP_XOR, 12'hB28});
      exec({OP_MOVE, 12'h08C});
      // rotate by 3, by 11 (wraps to 3) and by 0
      exec({OP_ROTATE, 12'h803});
      exec({OP_ROTATE, 12'h80B});
      exec({OP_ROTATE, 12'h800});
      exec({OP_STORE, 12'h800});
      exec({OP_STORE, 12'h1FF});
      exec({OP_JUMP_EQ, 12'h042});
      exec({OP_JUMP_EQ, 12'h110});
      exec({OP_HALT, 12'h000});
      exec({OP_HALT, 12'hFFF});
      exec({OP_BAD_ZERO, 12'h000});
      exec({OP_BAD_D, 12'h123});
      exec({OP_BAD_E, 12'h000});
      exec({OP_BAD_F, 12'hFFF});

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_REQUESTS / 2) drain_responses();
         pick = $urandom_range(0, 99);
         word = 16'($urandom);
         addr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
         if (pick < 10) begin
            send_request(MODE_LOAD, word, addr, 8'($urandom));
         end else begin
            if (pick < 30) word[15:12] = OP_LOAD_IMM;
            if (word[15:12] == OP_LOAD_MEM || word[15:12] == OP_STORE) word[7:0] = addr;
            if (word[15:12] == OP_STORE && $urandom_range(0, 4) == 0) word[7:0] = 8'h00;
            if (word[15:12] == OP_JUMP_EQ && $urandom_range(0, 2) == 0) word[11:8] = 4'h0;
            exec(word);
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/vole_pkg.sv
hw/rtl/vole_alu.sv
hw/rtl/vole_instruction_execute.sv
test/vole_checker.sv
test/testbench.sv
